>>> hdl/vti_pkg.sv
// ----------------------------------------------------------------------------
// vti_pkg - shared types and constants of the vector tween interpolator
// Field widths, event and mode codes, register indexes and the constants
// used to build the sine ease table.
// ----------------------------------------------------------------------------
package vti_pkg;

  // Field widths
  localparam int unsigned VAL_W   = 16;   // one Q8.8 component
  localparam int unsigned TIME_W  = 32;   // time stamps and durations
  localparam int unsigned WGT_W   = 17;   // Q0.16 weight, 0 .. 65536
  localparam int unsigned QUOT_W  = 16;   // divider quotient bits
  localparam int unsigned NUM_W   = TIME_W + QUOT_W;
  localparam int unsigned NCOMP   = 3;    // x, y, z

  // Result event codes
  localparam logic [1:0] EV_UPDATE = 2'd0;
  localparam logic [1:0] EV_FINISH = 2'd1;
  localparam logic [1:0] EV_START  = 2'd2;

  // Interpolation modes (the unused code behaves as linear)
  localparam logic [1:0] MODE_JUMP   = 2'd0;
  localparam logic [1:0] MODE_LINEAR = 2'd1;
  localparam logic [1:0] MODE_SINE   = 2'd2;

  // Input kinds
  localparam logic KIND_TICK   = 1'b0;
  localparam logic KIND_TARGET = 1'b1;

  // Configuration register indexes
  localparam logic REG_DURATION = 1'b0;
  localparam logic REG_MODE     = 1'b1;

  // Reset values of the configuration registers
  localparam logic [TIME_W-1:0] DURATION_RST = 32'd1000;
  localparam logic [1:0]        MODE_RST     = MODE_LINEAR;

  // pi in Q30 and the Taylor divisors (2k)(2k+1) for k = 1 .. 6
  localparam logic [63:0] PI_Q30 = 64'd3373259426;
  localparam logic [63:0] TAYLOR_DIV [6] = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156};

  // Divider status towards the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

>>> hdl/vti_div.sv
// ----------------------------------------------------------------------------
// vti_div - bit-serial restoring divider
// Divides a numerator known to give a quotient below 2^QUOT_W by the
// duration, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module vti_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [vti_pkg::NUM_W-1:0]   num_i,
  input  logic [vti_pkg::TIME_W-1:0]  den_i,
  output vti_pkg::div_stat_t          stat_o,
  output logic [vti_pkg::QUOT_W-1:0]  quot_o
);

  localparam int unsigned CNT_W = $clog2(vti_pkg::QUOT_W + 1);

  logic [vti_pkg::TIME_W-1:0] rem_q, rem_d;
  logic [vti_pkg::TIME_W-1:0] den_q;
  logic [vti_pkg::QUOT_W-1:0] low_q, low_d;
  logic [CNT_W-1:0]           cnt_q, cnt_d;
  logic                       busy_q, busy_d;
  logic                       done_q, done_d;
  logic [vti_pkg::TIME_W:0]   trial;
  logic                       fits;

  // Bring down the next numerator bit and try the subtraction
  assign trial = {rem_q, low_q[vti_pkg::QUOT_W-1]};
  assign fits  = trial >= {1'b0, den_q};

  always_comb begin
    rem_d  = rem_q;
    low_d  = low_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = num_i[vti_pkg::NUM_W-1:vti_pkg::QUOT_W];
      low_d  = num_i[vti_pkg::QUOT_W-1:0];
      cnt_d  = CNT_W'(vti_pkg::QUOT_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d  = fits ? vti_pkg::TIME_W'(trial - {1'b0, den_q})
                    : trial[vti_pkg::TIME_W-1:0];
      low_d  = {low_q[vti_pkg::QUOT_W-2:0], fits};
      cnt_d  = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Partial remainder and quotient shift register
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    low_q <= low_d;
    if (start_i) begin
      den_q <= den_i;
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quot_o      = low_q;

endmodule

>>> hdl/vti_lane.sv
// ----------------------------------------------------------------------------
// vti_lane - one component lane of the interpolator
// Scales the span between start and end by the Q0.16 weight, floors the
// product and adds it to the start value.
// ----------------------------------------------------------------------------
module vti_lane (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic signed [vti_pkg::VAL_W-1:0]  from_i,
  input  logic signed [vti_pkg::VAL_W-1:0]  to_i,
  input  logic [vti_pkg::WGT_W-1:0]         wgt_i,
  output logic signed [vti_pkg::VAL_W-1:0]  value_o
);

  localparam int unsigned DIFF_W = vti_pkg::VAL_W + 1;
  localparam int unsigned PROD_W = DIFF_W + vti_pkg::WGT_W + 1;

  logic signed [DIFF_W-1:0] diff;
  logic signed [PROD_W-1:0] prod_d, prod_q;
  logic signed [PROD_W-17:0] step;

  // Span times weight, registered before the add
  assign diff   = DIFF_W'(to_i) - DIFF_W'(from_i);
  assign prod_d = PROD_W'(diff) * PROD_W'($signed({1'b0, wgt_i}));

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
    end
  end

  // Dropping the low 16 bits of a two's complement value floors it
  assign step    = prod_q[PROD_W-1:16];
  assign value_o = from_i + step[vti_pkg::VAL_W-1:0];

endmodule

>>> hdl/vector_tween_interpolator_core.sv
// ----------------------------------------------------------------------------
// vector_tween_interpolator_core - three-component keyframe tween
// Animates an x/y/z Q8.8 value towards a target with jump, linear or sine
// ease interpolation, one component lane per axis.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats carry a tick (tuser 0) with the current time, or a new target
//   (tuser 1) with time, target and the object's present value. Output beats
//   carry the event code in tuser, the value in tdata and tlast on the final
//   result of an input beat.
//   A new target gives one or two beats (an early finish of a running
//   animation, then started), from ST_OLD and ST_NEW. A tick while running
//   gives one beat: finished or jump from ST_EVAL, linear or sine ease after
//   the 16-step serial divider, ST_WGT and ST_MUL; the next input beat is
//   taken once that beat is loaded. An idle tick gives nothing and frees the
//   input for the next cycle. Duration and mode are written through the cfg
//   port while the block is idle; the user must keep to this, as the block
//   does not enforce it. Reset leaves the block idle with duration 1000 and
//   linear mode. The output register holds a beat while the receiver stalls;
//   the next input beat is still taken and worked on up to its first result.
// ----------------------------------------------------------------------------
module vector_tween_interpolator_core #(
  parameter int unsigned EASE_TABLE_DEPTH = 256
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // Input stream
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // now[31:0], target_x, target_y, target_z, current_x, current_y, current_z
  input  logic [127:0] s_axis_tdata,
  // kind[0]
  input  logic [0:0]   s_axis_tuser,
  // Output stream
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // value_x[15:0], value_y[31:16], value_z[47:32]
  output logic [47:0]  m_axis_tdata,
  // event_res[1:0]
  output logic [1:0]   m_axis_tuser,
  output logic         m_axis_tlast,
  // Configuration write port
  input  logic         cfg_we_i,
  input  logic [0:0]   cfg_idx_i,
  input  logic [31:0]  cfg_data_i
);

  localparam int unsigned IDX_W   = $clog2(EASE_TABLE_DEPTH);
  localparam logic [63:0] EASE_DEN = 64'(2 * EASE_TABLE_DEPTH);
  localparam int unsigned VW      = vti_pkg::VAL_W;
  localparam int unsigned NC      = vti_pkg::NCOMP;

  // Sequencer states
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_OLD  = 3'd1;
  localparam logic [2:0] ST_NEW  = 3'd2;
  localparam logic [2:0] ST_EVAL = 3'd3;
  localparam logic [2:0] ST_DIV  = 3'd4;
  localparam logic [2:0] ST_WGT  = 3'd5;
  localparam logic [2:0] ST_MUL  = 3'd6;
  localparam logic [2:0] ST_UPD  = 3'd7;

  // Sine ease weight sin^2(pi*i/(2*depth)) in Q0.16, fixed integer series
  function automatic logic [vti_pkg::WGT_W-1:0] ease_val(input int unsigned idx);
    logic [63:0] y, y2, term, sum, sq;
    y    = (vti_pkg::PI_Q30 * 64'(idx)) / EASE_DEN;
    y2   = (y * y) >> 30;
    term = y;
    sum  = y;
    for (int k = 0; k < 6; k++) begin
      term = (term * y2) >> 30;
      term = term / vti_pkg::TAYLOR_DIV[k];
      if (k[0] == 1'b0) begin
        sum = (sum >= term) ? sum - term : 64'd0;
      end else begin
        sum = sum + term;
      end
    end
    if (sum > (64'd1 << 30)) begin
      sum = 64'd1 << 30;
    end
    sq = (((sum * sum) >> 30) + 64'd8192) >> 14;
    if (sq > 64'd65536) begin
      sq = 64'd65536;
    end
    return sq[vti_pkg::WGT_W-1:0];
  endfunction

  logic [vti_pkg::WGT_W-1:0] ease_tab [EASE_TABLE_DEPTH];

  // Constant ease table
  for (genvar g = 0; g < EASE_TABLE_DEPTH; g++) begin : g_tab
    assign ease_tab[g] = ease_val(g);
  end

  logic [2:0]                   state_q, state_d;
  logic [vti_pkg::TIME_W-1:0]   duration_q;
  logic [1:0]                   mode_q;
  logic                         running_q, running_d;
  logic [vti_pkg::TIME_W-1:0]   begin_q;
  logic signed [VW-1:0]         from_q [NC];
  logic signed [VW-1:0]         to_q   [NC];
  logic [vti_pkg::TIME_W-1:0]   now_q;
  logic signed [VW-1:0]         tgt_q  [NC];
  logic signed [VW-1:0]         cur_q  [NC];
  logic [vti_pkg::TIME_W-1:0]   dt_q;
  logic [vti_pkg::WGT_W-1:0]    wgt_q;

  logic                         m_valid_q, m_valid_d;
  logic [47:0]                  m_data_q, m_data_d;
  logic [1:0]                   m_user_q, m_user_d;
  logic                         m_last_q, m_last_d;
  logic                         out_load;
  logic                         out_free;

  logic                         in_acc;
  logic                         cap_item;
  logic                         cap_dt;
  logic                         latch_new;
  logic                         wgt_en;
  logic                         lane_en;
  logic                         div_start;
  logic [vti_pkg::NUM_W-1:0]    div_num;
  vti_pkg::div_stat_t           div_stat;
  logic [vti_pkg::QUOT_W-1:0]   quot;
  logic [IDX_W-1:0]             ease_idx;
  logic [vti_pkg::WGT_W-1:0]    wgt_d;
  logic signed [VW-1:0]         lane_val [NC];
  logic                         dt_done;
  logic                         jump_early;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;

  assign dt_done    = dt_q >= duration_q;
  assign jump_early = {dt_q, 1'b0} < {1'b0, duration_q};

  // Divider numerator: time scaled by the table depth or by 2^16
  assign div_num = (mode_q == vti_pkg::MODE_SINE)
                 ? vti_pkg::NUM_W'(dt_q) * vti_pkg::NUM_W'(EASE_TABLE_DEPTH)
                 : {dt_q, {vti_pkg::QUOT_W{1'b0}}};

  vti_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (duration_q),
    .stat_o  (div_stat),
    .quot_o  (quot)
  );

  // Pick the weight: table entry for sine ease, quotient otherwise
  assign ease_idx = (quot >= vti_pkg::QUOT_W'(EASE_TABLE_DEPTH))
                  ? IDX_W'(EASE_TABLE_DEPTH - 1) : quot[IDX_W-1:0];
  assign wgt_d    = (mode_q == vti_pkg::MODE_SINE) ? ease_tab[ease_idx]
                                                   : {1'b0, quot};

  // Component lanes
  for (genvar c = 0; c < NC; c++) begin : g_lane
    vti_lane u_lane (
      .clk_i   (clk_i),
      .en_i    (lane_en),
      .from_i  (from_q[c]),
      .to_i    (to_q[c]),
      .wgt_i   (wgt_q),
      .value_o (lane_val[c])
    );
  end

  // Sequencer and merging into the output register
  always_comb begin
    state_d   = state_q;
    running_d = running_q;
    cap_item  = 1'b0;
    cap_dt    = 1'b0;
    latch_new = 1'b0;
    wgt_en    = 1'b0;
    lane_en   = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    m_user_d  = m_user_q;
    m_last_d  = m_last_q;
    m_data_d  = m_data_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (s_axis_tuser[0] == vti_pkg::KIND_TARGET) begin
            cap_item = 1'b1;
            state_d  = running_q ? ST_OLD : ST_NEW;
          end else if (running_q) begin
            cap_dt  = 1'b1;
            state_d = ST_EVAL;
          end
        end
      end
      ST_OLD: begin
        if (out_free) begin
          out_load = 1'b1;
          m_user_d = vti_pkg::EV_FINISH;
          m_last_d = 1'b0;
          m_data_d = {to_q[2], to_q[1], to_q[0]};
          state_d  = ST_NEW;
        end
      end
      ST_NEW: begin
        if (out_free) begin
          out_load  = 1'b1;
          latch_new = 1'b1;
          running_d = 1'b1;
          m_user_d  = vti_pkg::EV_START;
          m_last_d  = 1'b1;
          m_data_d  = {cur_q[2], cur_q[1], cur_q[0]};
          state_d   = ST_IDLE;
        end
      end
      ST_EVAL: begin
        if (dt_done) begin
          if (out_free) begin
            out_load  = 1'b1;
            running_d = 1'b0;
            m_user_d  = vti_pkg::EV_FINISH;
            m_last_d  = 1'b1;
            m_data_d  = {to_q[2], to_q[1], to_q[0]};
            state_d   = ST_IDLE;
          end
        end else if (mode_q == vti_pkg::MODE_JUMP) begin
          if (out_free) begin
            out_load = 1'b1;
            m_user_d = vti_pkg::EV_UPDATE;
            m_last_d = 1'b1;
            m_data_d = jump_early ? {from_q[2], from_q[1], from_q[0]}
                                  : {to_q[2], to_q[1], to_q[0]};
            state_d  = ST_IDLE;
          end
        end else begin
          div_start = 1'b1;
          state_d   = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_stat.done) begin
          state_d = ST_WGT;
        end
      end
      ST_WGT: begin
        wgt_en  = 1'b1;
        state_d = ST_MUL;
      end
      ST_MUL: begin
        lane_en = 1'b1;
        state_d = ST_UPD;
      end
      ST_UPD: begin
        if (out_free) begin
          out_load = 1'b1;
          m_user_d = vti_pkg::EV_UPDATE;
          m_last_d = 1'b1;
          m_data_d = {lane_val[2], lane_val[1], lane_val[0]};
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Output valid: set on load, drop when taken
  always_comb begin
    m_valid_d = m_valid_q;
    if (out_load) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
  end

  // Control state and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      running_q  <= 1'b0;
      m_valid_q  <= 1'b0;
      duration_q <= vti_pkg::DURATION_RST;
      mode_q     <= vti_pkg::MODE_RST;
    end else begin
      state_q   <= state_d;
      running_q <= running_d;
      m_valid_q <= m_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          vti_pkg::REG_DURATION: duration_q <= cfg_data_i;
          vti_pkg::REG_MODE:     mode_q     <= cfg_data_i[1:0];
          default:               mode_q     <= mode_q;
        endcase
      end
    end
  end

  // Item, animation and output payload
  always_ff @(posedge clk_i) begin
    if (cap_item) begin
      now_q <= s_axis_tdata[31:0];
      for (int c = 0; c < NC; c++) begin
        tgt_q[c] <= s_axis_tdata[32 + VW*c +: VW];
        cur_q[c] <= s_axis_tdata[80 + VW*c +: VW];
      end
    end
    if (cap_dt) begin
      dt_q <= s_axis_tdata[31:0] - begin_q;
    end
    if (latch_new) begin
      begin_q <= now_q;
      for (int c = 0; c < NC; c++) begin
        from_q[c] <= cur_q[c];
        to_q[c]   <= tgt_q[c];
      end
    end
    if (wgt_en) begin
      wgt_q <= wgt_d;
    end
    m_data_q <= m_data_d;
    m_user_q <= m_user_d;
    m_last_q <= m_last_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;
  assign m_axis_tlast  = m_last_q;

endmodule

>>> hdl/vti_chk.sv
// ----------------------------------------------------------------------------
// vti_chk - port checker for the vector tween interpolator
// Watches the stream ports of the top level and flags misbehaviour.
// ----------------------------------------------------------------------------
module vti_chk (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic [0:0]   s_axis_tuser,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [47:0]  m_axis_tdata,
  input logic [1:0]   m_axis_tuser,
  input logic         m_axis_tlast
);

  // Hold a stalled output beat
  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output beat dropped while stalled");

  // Keep a stalled output payload
  a_out_stable : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("output payload changed while stalled");

  // Only the early finish of a running animation can be a non-final beat
  a_nonlast_finish : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> m_axis_tuser == vti_pkg::EV_FINISH)
    else $error("non-final beat is not a finish");

  // A new target always produces results, so input is closed next cycle
  a_target_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tuser[0] == vti_pkg::KIND_TARGET
      |=> !s_axis_tready)
    else $error("input still open after a new target");

endmodule

bind vector_tween_interpolator_core vti_chk u_vti_chk (.*);
